// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/elr_pkg.sv =====
// ----------------------------------------------------------------------------
// elr_pkg
// Constants, codes and types of the ellipse rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package elr_pkg;

   localparam int AXIS_BITS_DEFAULT = 9;
   localparam int CENTER_W          = 10;
   localparam int COORD_W           = 12;
   localparam int CSR_INDEX_W       = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEMI_AXIS_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEMI_AXIS_Y = 1'b1;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef enum logic [13:0] {
      S_IDLE  = 14'h0001,
      S_SQA   = 14'h0002,
      S_SQB   = 14'h0004,
      S_LOAD  = 14'h0008,
      S_INIT  = 14'h0010,
      S_INIT2 = 14'h0020,
      S_INC   = 14'h0040,
      S_TERM  = 14'h0080,
      S_ACC   = 14'h0100,
      S_USQ   = 14'h0200,
      S_OWN2  = 14'h0400,
      S_CMP   = 14'h0800,
      S_SW    = 14'h1000,
      S_DONE  = 14'h2000
   } elr_state_type;

endpackage

`default_nettype wire

// ===== rtl/elr_mul.sv =====
// ----------------------------------------------------------------------------
// elr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module elr_mul #(
   parameter int WIDTH = 22
) (
   input  wire logic               clock,
   input  wire logic [WIDTH-1:0]   op_a,
   input  wire logic [WIDTH-1:0]   op_b,
   output logic      [2*WIDTH-1:0] prod_ff
);

   logic signed [WIDTH-1:0]   sa;
   logic signed [WIDTH-1:0]   sb;
   logic signed [2*WIDTH-1:0] prod_in;

   assign sa      = op_a;
   assign sb      = op_b;
   assign prod_in = sa * sb;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ===== rtl/ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// ellipse_rasterizer
// Midpoint ellipse walker in two regions with four-way mirrored output.
//
// csr_we/csr_index/csr_wdata set semi-axes a (index 0) and b (index 1),
// zero is taken as one; write only while the block is idle.
// req_*: a start item (req_type 0) latches the center and arms a new walk;
// a step item (req_type 1) yields one rsp item of four mirrored points and
// last_step, then advances the walk. Steps with no walk armed give nothing.
// One shared registered multiplier serves all products under a sequencer,
// so req_stall stays high while an item is worked on. A start item passes
// S_SQA, S_SQB, S_LOAD, S_INIT and S_INIT2; a step item passes S_SQA, S_SQB,
// S_LOAD, S_INC, S_TERM, S_ACC, S_USQ, S_OWN2, S_CMP, S_SW only at the
// region change, and S_DONE. The rsp side has an output register; the next
// item is taken while a result waits, and a finished step holds in its last
// state while rsp is stalled with a result still pending.
// Reset (synchronous): a = b = 1, no walk armed, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ellipse_rasterizer #(
   parameter int AXIS_BITS = elr_pkg::AXIS_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [elr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [AXIS_BITS-1:0]            csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_type,
   input  wire logic [elr_pkg::CENTER_W-1:0]    req_center_x_in,
   input  wire logic [elr_pkg::CENTER_W-1:0]    req_center_y_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt0_x,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt0_y,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt1_x,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt1_y,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt2_x,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt2_y,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt3_x,
   output logic signed [elr_pkg::COORD_W-1:0]   rsp_pt3_y,
   output logic                                 rsp_last_step
);

   localparam int AB = AXIS_BITS;
   localparam int CW = elr_pkg::CENTER_W;
   localparam int OW = elr_pkg::COORD_W;
   localparam int ST = AB + 3;        // signed step coordinate
   localparam int SQ = 2 * AB;        // axis square
   localparam int MW = 2 * AB + 4;    // multiplier operand
   localparam int PW = 2 * MW;        // product and decision
   localparam int SW = ST + OW;       // point sum before wrap

   elr_pkg::elr_state_type state_ff, state_in;

   logic [AB-1:0] semi_x_ff, semi_x_in;
   logic [AB-1:0] semi_y_ff, semi_y_in;
   logic          active_ff, active_in;
   logic          region_ff, region_in;
   logic [ST-1:0] step_x_ff, step_x_in;
   logic [ST-1:0] step_y_ff, step_y_in;
   logic [PW-1:0] dec_ff, dec_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] cx_ff, cx_in;
   logic [CW-1:0] cy_ff, cy_in;
   logic          start_ff, start_in;
   logic [ST-1:0] old_x_ff, old_x_in;
   logic [ST-1:0] old_y_ff, old_y_in;
   logic [SQ-1:0] a2_ff, a2_in;
   logic [SQ-1:0] b2_ff, b2_in;
   logic [PW-1:0] inc_ff, inc_in;
   logic [PW-1:0] lhs_ff, lhs_in;
   logic          last_ff, last_in;
   logic [OW-1:0] x_plus_ff, x_plus_in;
   logic [OW-1:0] x_minus_ff, x_minus_in;
   logic [OW-1:0] y_plus_ff, y_plus_in;
   logic [OW-1:0] y_minus_ff, y_minus_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [MW-1:0] op_a;
   logic [MW-1:0] op_b;
   logic [PW-1:0] mul_prod;

   logic [AB-1:0] a_eff;
   logic [AB-1:0] b_eff;
   logic [SQ:0]   axis_sum;
   logic [SQ-1:0] own_sq;
   logic [SQ-1:0] other_sq;
   logic [ST-1:0] u_cur;
   logic [ST-1:0] v_cur;
   logic [ST-1:0] u_inc;
   logic [ST-1:0] v_dec;
   logic [ST:0]   u_twice_p3;
   logic [ST:0]   one_minus_v;
   logic [MW-1:0] one_minus_2a;
   logic [MW-1:0] one_minus_2b;
   logic          dec_nonneg;
   logic [PW-1:0] dec_step;
   logic          bound_fail;
   logic          rsp_free;

   logic [SW-1:0] cx_ext;
   logic [SW-1:0] cy_ext;
   logic [SW-1:0] ox_ext;
   logic [SW-1:0] oy_ext;
   logic [SW-1:0] sum_x_plus;
   logic [SW-1:0] sum_x_minus;
   logic [SW-1:0] sum_y_plus;
   logic [SW-1:0] sum_y_minus;

   elr_mul #(
      .WIDTH (MW)
   ) u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (mul_prod)
   );

   assign a_eff    = (semi_x_ff == '0) ? AB'(1) : semi_x_ff;
   assign b_eff    = (semi_y_ff == '0) ? AB'(1) : semi_y_ff;
   assign axis_sum = {1'b0, a2_ff} + {1'b0, b2_ff};

   // region one walks x against a*a, region two walks y against b*b
   assign own_sq   = region_ff ? b2_ff : a2_ff;
   assign other_sq = region_ff ? a2_ff : b2_ff;
   assign u_cur    = region_ff ? step_y_ff : step_x_ff;
   assign v_cur    = region_ff ? step_x_ff : step_y_ff;

   assign u_inc        = u_cur + ST'(1);
   assign v_dec        = v_cur - ST'(1);
   assign u_twice_p3   = {u_cur, 1'b0} + (ST+1)'(3);
   assign one_minus_v  = (ST+1)'(1) - {v_cur[ST-1], v_cur};
   assign one_minus_2a = MW'(1) - {{(MW-AB-1){1'b0}}, a_eff, 1'b0};
   assign one_minus_2b = MW'(1) - {{(MW-AB-1){1'b0}}, b_eff, 1'b0};

   assign dec_nonneg = ~dec_ff[PW-1];
   assign dec_step   = dec_ff + {inc_ff[PW-2:0], 1'b0}
                     + (dec_nonneg ? {mul_prod[PW-3:0], 2'b00} : PW'(0));
   assign bound_fail = $signed(lhs_ff) > $signed(mul_prod);
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   assign cx_ext      = {{(SW-CW){1'b0}}, cx_ff};
   assign cy_ext      = {{(SW-CW){1'b0}}, cy_ff};
   assign ox_ext      = {{(SW-ST){old_x_ff[ST-1]}}, old_x_ff};
   assign oy_ext      = {{(SW-ST){old_y_ff[ST-1]}}, old_y_ff};
   assign sum_x_plus  = cx_ext + ox_ext;
   assign sum_x_minus = cx_ext - ox_ext;
   assign sum_y_plus  = cy_ext + oy_ext;
   assign sum_y_minus = cy_ext - oy_ext;

   always_comb begin
      state_in     = state_ff;
      semi_x_in    = semi_x_ff;
      semi_y_in    = semi_y_ff;
      active_in    = active_ff;
      region_in    = region_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      dec_in       = dec_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      start_in     = start_ff;
      old_x_in     = old_x_ff;
      old_y_in     = old_y_ff;
      a2_in        = a2_ff;
      b2_in        = b2_ff;
      inc_in       = inc_ff;
      lhs_in       = lhs_ff;
      last_in      = last_ff;
      x_plus_in    = x_plus_ff;
      x_minus_in   = x_minus_ff;
      y_plus_in    = y_plus_ff;
      y_minus_in   = y_minus_ff;
      rsp_last_in  = rsp_last_ff;
      op_a         = '0;
      op_b         = '0;

      if (csr_we) begin
         case (csr_index)
            elr_pkg::CSR_SEMI_AXIS_X: semi_x_in = csr_wdata;
            elr_pkg::CSR_SEMI_AXIS_Y: semi_y_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         elr_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_type == elr_pkg::REQ_START) begin
                  cx_in    = req_center_x_in;
                  cy_in    = req_center_y_in;
                  start_in = 1'b1;
                  state_in = elr_pkg::S_SQA;
               end else if (active_ff) begin
                  old_x_in = step_x_ff;
                  old_y_in = step_y_ff;
                  start_in = 1'b0;
                  state_in = elr_pkg::S_SQA;
               end
            end
         end
         elr_pkg::S_SQA: begin
            op_a     = {{(MW-AB){1'b0}}, a_eff};
            op_b     = {{(MW-AB){1'b0}}, a_eff};
            state_in = elr_pkg::S_SQB;
         end
         elr_pkg::S_SQB: begin
            a2_in    = mul_prod[SQ-1:0];
            op_a     = {{(MW-AB){1'b0}}, b_eff};
            op_b     = {{(MW-AB){1'b0}}, b_eff};
            state_in = elr_pkg::S_LOAD;
         end
         elr_pkg::S_LOAD: begin
            b2_in    = mul_prod[SQ-1:0];
            state_in = start_ff ? elr_pkg::S_INIT : elr_pkg::S_INC;
         end
         elr_pkg::S_INIT: begin
            op_a     = {{(MW-SQ){1'b0}}, a2_ff};
            op_b     = one_minus_2b;
            state_in = elr_pkg::S_INIT2;
         end
         elr_pkg::S_INIT2: begin
            dec_in    = mul_prod + {{(PW-SQ-1){1'b0}}, b2_ff, 1'b0};
            active_in = 1'b1;
            region_in = 1'b0;
            step_x_in = '0;
            step_y_in = {{(ST-AB){1'b0}}, b_eff};
            state_in  = elr_pkg::S_IDLE;
         end
         elr_pkg::S_INC: begin
            op_a     = {{(MW-SQ){1'b0}}, other_sq};
            op_b     = {{(MW-ST-1){u_twice_p3[ST]}}, u_twice_p3};
            state_in = elr_pkg::S_TERM;
         end
         elr_pkg::S_TERM: begin
            inc_in   = mul_prod;
            op_a     = {{(MW-SQ){1'b0}}, own_sq};
            op_b     = {{(MW-ST-1){one_minus_v[ST]}}, one_minus_v};
            state_in = elr_pkg::S_ACC;
         end
         elr_pkg::S_ACC: begin
            dec_in = dec_step;
            if (region_ff) begin
               step_y_in = u_inc;
               step_x_in = dec_nonneg ? v_dec : v_cur;
            end else begin
               step_x_in = u_inc;
               step_y_in = dec_nonneg ? v_dec : v_cur;
            end
            op_a     = {{(MW-ST){u_inc[ST-1]}}, u_inc};
            op_b     = {{(MW-ST){u_inc[ST-1]}}, u_inc};
            state_in = elr_pkg::S_USQ;
         end
         elr_pkg::S_USQ: begin
            op_a     = mul_prod[MW-1:0];
            op_b     = {{(MW-SQ-1){1'b0}}, axis_sum};
            state_in = elr_pkg::S_OWN2;
         end
         elr_pkg::S_OWN2: begin
            lhs_in   = mul_prod;
            op_a     = {{(MW-SQ){1'b0}}, own_sq};
            op_b     = {{(MW-SQ){1'b0}}, own_sq};
            state_in = elr_pkg::S_CMP;
         end
         elr_pkg::S_CMP: begin
            last_in  = 1'b0;
            state_in = elr_pkg::S_DONE;
            if (bound_fail) begin
               if (region_ff) begin
                  last_in   = 1'b1;
                  active_in = 1'b0;
               end else begin
                  region_in = 1'b1;
                  step_x_in = {{(ST-AB){1'b0}}, a_eff};
                  step_y_in = '0;
                  op_a      = {{(MW-SQ){1'b0}}, b2_ff};
                  op_b      = one_minus_2a;
                  state_in  = elr_pkg::S_SW;
               end
            end
         end
         elr_pkg::S_SW: begin
            dec_in   = mul_prod + {{(PW-SQ-1){1'b0}}, a2_ff, 1'b0};
            state_in = elr_pkg::S_DONE;
         end
         elr_pkg::S_DONE: begin
            if (rsp_free) begin
               x_plus_in    = sum_x_plus[OW-1:0];
               x_minus_in   = sum_x_minus[OW-1:0];
               y_plus_in    = sum_y_plus[OW-1:0];
               y_minus_in   = sum_y_minus[OW-1:0];
               rsp_last_in  = last_ff;
               rsp_valid_in = 1'b1;
               state_in     = elr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = elr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= elr_pkg::S_IDLE;
         semi_x_ff    <= AB'(1);
         semi_y_ff    <= AB'(1);
         active_ff    <= 1'b0;
         region_ff    <= 1'b0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         dec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         semi_x_ff    <= semi_x_in;
         semi_y_ff    <= semi_y_in;
         active_ff    <= active_in;
         region_ff    <= region_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      start_ff    <= start_in;
      old_x_ff    <= old_x_in;
      old_y_ff    <= old_y_in;
      a2_ff       <= a2_in;
      b2_ff       <= b2_in;
      inc_ff      <= inc_in;
      lhs_ff      <= lhs_in;
      last_ff     <= last_in;
      x_plus_ff   <= x_plus_in;
      x_minus_ff  <= x_minus_in;
      y_plus_ff   <= y_plus_in;
      y_minus_ff  <= y_minus_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall     = (state_ff != elr_pkg::S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pt0_x     = x_plus_ff;
   assign rsp_pt0_y     = y_plus_ff;
   assign rsp_pt1_x     = x_plus_ff;
   assign rsp_pt1_y     = y_minus_ff;
   assign rsp_pt2_x     = x_minus_ff;
   assign rsp_pt2_y     = y_plus_ff;
   assign rsp_pt3_x     = x_minus_ff;
   assign rsp_pt3_y     = y_minus_ff;
   assign rsp_last_step = rsp_last_ff;

   // a new result only ever comes out of the final sequencer state
   `ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
                $past(state_ff == elr_pkg::S_DONE), "rsp item without finished step")
   // the final point of a walk leaves no walk armed
   `ASSERT_SAME(a_last_disarms, clock, reset, $rose(rsp_valid_ff) && rsp_last_ff,
                !active_ff, "walk still armed after last item")
   // region two walks y up from zero
   `ASSERT_ALWAYS(a_y_nonneg, clock, reset, !region_ff || !step_y_ff[ST-1],
                  "negative y in region two")
   // a finished step with a free output slot completes at once
   `ASSERT_NEXT(a_done_leaves, clock, reset,
                state_ff == elr_pkg::S_DONE && rsp_free,
                state_ff == elr_pkg::S_IDLE && rsp_valid_ff, "step result not delivered")

endmodule

`default_nettype wire
